### rtl/slrm_pkg.sv
// shared types and constants of the saturating linear range mapper
package slrm_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int SPAN_W         = SAMPLE_W + 1;
   localparam int GAIN_W         = 32;
   localparam int GAIN_FRAC_BITS = 14;
   localparam int DIV_STEPS      = SAMPLE_W + GAIN_FRAC_BITS;
   localparam int PROD_W         = SPAN_W + GAIN_W;
   localparam int SHIFT_W        = PROD_W - GAIN_FRAC_BITS;

   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32767;

   localparam logic signed [SAMPLE_W-1:0] OUT_LOW_RESET  = -16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] OUT_HIGH_RESET = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] IN_LOW_RESET   = -16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] IN_HIGH_RESET  = 16'sd32767;
   localparam logic signed [GAIN_W-1:0]   GAIN_RESET     = 32'sd16384;

   typedef enum logic [1:0] {
      CSR_OUT_LOW_END  = 2'd0,
      CSR_OUT_HIGH_END = 2'd1,
      CSR_IN_LOW_END   = 2'd2,
      CSR_IN_HIGH_END  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       block_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       block_end_out;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_low_end;
      logic signed [SAMPLE_W-1:0] out_high_end;
      logic signed [SAMPLE_W-1:0] in_low_end;
      logic signed [SAMPLE_W-1:0] in_high_end;
   } range_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/slrm_gain_div.sv
// restoring divider for the q14 gain, one quotient bit per cycle
module slrm_gain_div
   import slrm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SPAN_W-1:0] out_span,
   input  logic signed [SPAN_W-1:0] in_span,
   output div_status_type           status,
   output logic signed [GAIN_W-1:0] quotient
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SPAN_W-1:0]         rem_ff, rem_in;
   logic [DIV_STEPS-1:0]      dividend_ff, dividend_in;
   logic [DIV_STEPS-1:0]      quo_ff, quo_in;
   logic [SPAN_W-1:0]         divisor_ff, divisor_in;
   logic                      neg_ff, neg_in;
   logic                      done_ff, done_in;
   logic signed [GAIN_W-1:0]  result_ff, result_in;

   logic [SPAN_W-1:0]         out_abs;
   logic [SPAN_W-1:0]         in_abs;
   logic [SPAN_W:0]           trial;
   logic                      fits;
   logic [DIV_STEPS-1:0]      quo_next;
   logic signed [GAIN_W-1:0]  quo_wide;

   assign out_abs  = out_span[SPAN_W-1] ? SPAN_W'(-out_span) : SPAN_W'(out_span);
   assign in_abs   = in_span[SPAN_W-1] ? SPAN_W'(-in_span) : SPAN_W'(in_span);
   assign trial    = {rem_ff, dividend_ff[DIV_STEPS-1]};
   assign fits     = trial >= {1'b0, divisor_ff};
   assign quo_next = {quo_ff[DIV_STEPS-2:0], fits};
   assign quo_wide = GAIN_W'($signed({1'b0, quo_next}));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      dividend_in = dividend_ff;
      quo_in      = quo_ff;
      divisor_in  = divisor_ff;
      neg_in      = neg_ff;
      done_in     = 1'b0;
      result_in   = result_ff;
      if (start) begin
         count_in    = '0;
         rem_in      = '0;
         dividend_in = {out_abs[SAMPLE_W-1:0], {GAIN_FRAC_BITS{1'b0}}};
         quo_in      = '0;
         divisor_in  = in_abs;
         neg_in      = out_span[SPAN_W-1] ^ in_span[SPAN_W-1];
         if (in_abs == '0) begin
            state_in  = ST_IDLE;
            result_in = '0;
            done_in   = 1'b1;
         end else begin
            state_in = ST_RUN;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_RUN: begin
               rem_in      = fits ? SPAN_W'(trial - {1'b0, divisor_ff}) : SPAN_W'(trial);
               dividend_in = {dividend_ff[DIV_STEPS-2:0], 1'b0};
               quo_in      = quo_next;
               count_in    = count_ff + 1'b1;
               if (count_ff == LAST_STEP) begin
                  state_in  = ST_IDLE;
                  result_in = neg_ff ? -quo_wide : quo_wide;
                  done_in   = 1'b1;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         done_ff   <= 1'b0;
         result_ff <= GAIN_RESET;
      end else begin
         state_ff  <= state_in;
         done_ff   <= done_in;
         result_ff <= result_in;
      end
      count_ff    <= count_in;
      rem_ff      <= rem_in;
      dividend_ff <= dividend_in;
      quo_ff      <= quo_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
   end

   assign status.busy = (state_ff == ST_RUN);
   assign status.done = done_ff;
   assign quotient    = result_ff;

endmodule

### rtl/slrm_map_pipe.sv
// sample register, mapping datapath with saturation, and result register
module slrm_map_pipe
   import slrm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  range_cfg_type            cfg,
   input  logic signed [GAIN_W-1:0] gain,
   input  logic                     hold,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_payload
);

   logic                       s1_valid_ff, s1_valid_in;
   req_payload_type            s1_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_data_ff;

   logic                       out_free;
   logic                       s1_move;
   logic                       req_fire;

   logic signed [SPAN_W-1:0]   mid_sum;
   logic signed [SPAN_W-1:0]   mid_adj;
   logic signed [SAMPLE_W-1:0] mid;
   logic signed [SPAN_W-1:0]   delta;
   logic signed [PROD_W-1:0]   prod;
   logic signed [SHIFT_W:0]    scaled;
   logic signed [SAMPLE_W-1:0] general;
   logic signed [SAMPLE_W-1:0] mapped;
   rsp_payload_type            rsp_data_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = (!s1_valid_ff || out_free) && !hold;
   assign req_fire  = req_valid && req_ready;

   // midpoint, truncated toward zero
   assign mid_sum = SPAN_W'(cfg.out_low_end) + SPAN_W'(cfg.out_high_end);
   assign mid_adj = mid_sum + SPAN_W'(mid_sum[SPAN_W-1]);
   assign mid     = SAMPLE_W'(mid_adj >>> 1);

   // general path: floor((x - in_low) * gain / 2^14) + out_low, saturated
   assign delta  = SPAN_W'(s1_data_ff.sample_in) - SPAN_W'(cfg.in_low_end);
   assign prod   = PROD_W'(delta) * PROD_W'(gain);
   assign scaled = (SHIFT_W + 1)'($signed(prod[PROD_W-1:GAIN_FRAC_BITS]))
                 + (SHIFT_W + 1)'(cfg.out_low_end);

   always_comb begin
      if (scaled > (SHIFT_W + 1)'(SAT_MAX)) begin
         general = SAT_MAX;
      end else if (scaled < (SHIFT_W + 1)'(SAT_MIN)) begin
         general = SAT_MIN;
      end else begin
         general = SAMPLE_W'(scaled);
      end
   end

   always_comb begin
      if (cfg.out_high_end == cfg.out_low_end) begin
         mapped = cfg.out_low_end;
      end else if (cfg.in_high_end == cfg.in_low_end) begin
         mapped = mid;
      end else if (s1_data_ff.sample_in == cfg.in_low_end) begin
         mapped = cfg.out_low_end;
      end else if (s1_data_ff.sample_in == cfg.in_high_end) begin
         mapped = cfg.out_high_end;
      end else begin
         mapped = general;
      end
   end

   assign rsp_data_in.sample_out    = mapped;
   assign rsp_data_in.block_end_out = s1_data_ff.block_end;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         s1_data_ff <= req_payload;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### rtl/saturating_linear_range_mapper_unit.sv
// top level: range registers, gain divider and two-register mapping pipeline
// a sample beat taken on req passes the sample and result registers to rsp
// throughput: one sample per cycle with a single multiply, while rsp is ready
// a csr write reruns the gain divider (30 steps, one quotient bit per cycle),
// and req is held off from the write cycle until the new gain is loaded
// reset (synchronous): ranges to +/-32767, gain to 16384, pipeline empty
module saturating_linear_range_mapper_unit
   import slrm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_index_type       csr_index,
   input  logic [SAMPLE_W-1:0] csr_wdata
);

   range_cfg_type            cfg_ff, cfg_in;
   logic                     pend_ff, pend_in;
   logic signed [GAIN_W-1:0] gain_ff, gain_in;
   logic                     csr_fire;
   logic signed [SPAN_W-1:0] out_span;
   logic signed [SPAN_W-1:0] in_span;
   div_status_type           div_status;
   logic signed [GAIN_W-1:0] div_quotient;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_OUT_LOW_END:  cfg_in.out_low_end  = $signed(csr_wdata);
            CSR_OUT_HIGH_END: cfg_in.out_high_end = $signed(csr_wdata);
            CSR_IN_LOW_END:   cfg_in.in_low_end   = $signed(csr_wdata);
            CSR_IN_HIGH_END:  cfg_in.in_high_end  = $signed(csr_wdata);
            default:          cfg_in = cfg_ff;
         endcase
      end
      pend_in = csr_fire;
      gain_in = div_status.done ? div_quotient : gain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_low_end  <= OUT_LOW_RESET;
         cfg_ff.out_high_end <= OUT_HIGH_RESET;
         cfg_ff.in_low_end   <= IN_LOW_RESET;
         cfg_ff.in_high_end  <= IN_HIGH_RESET;
         pend_ff             <= 1'b0;
         gain_ff             <= GAIN_RESET;
      end else begin
         cfg_ff  <= cfg_in;
         pend_ff <= pend_in;
         gain_ff <= gain_in;
      end
   end

   assign out_span = SPAN_W'(cfg_ff.out_high_end) - SPAN_W'(cfg_ff.out_low_end);
   assign in_span  = SPAN_W'(cfg_ff.in_high_end) - SPAN_W'(cfg_ff.in_low_end);

   slrm_gain_div u_gain_div (
      .clock    (clock),
      .reset    (reset),
      .start    (pend_ff),
      .out_span (out_span),
      .in_span  (in_span),
      .status   (div_status),
      .quotient (div_quotient)
   );

   slrm_map_pipe u_map_pipe (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .gain        (gain_ff),
      .hold        (pend_ff || div_status.busy || div_status.done || csr_fire),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
